### hw/rtl/mkse_pkg.sv
// ----------------------------------------------------------------------------
// mkse_pkg: shared types and constants of the Morse keying span encoder
// Holds the request and result formats, the symbol and prosign tables and
// the fixed constants of the keying arithmetic.
// ----------------------------------------------------------------------------
package mkse_pkg;

    // Fixed widths and constants of the keying arithmetic.
    localparam int unsigned WPM_W       = 7;
    localparam int unsigned DOT_W       = 28;
    localparam int unsigned UNITS_W     = 16;
    localparam int unsigned TOTAL_W     = 44;
    localparam int unsigned DIV_NUM_W   = 31;
    localparam logic [DIV_NUM_W-1:0] DOT_NUMERATOR = 31'd1200000000;
    localparam logic [DOT_W-1:0]     DOT_RESET     = 28'd60000000;
    localparam logic [WPM_W-1:0]     WPM_RESET     = 7'd20;
    localparam logic [WPM_W-1:0]     WPM_MIN       = 7'd5;
    localparam logic [WPM_W-1:0]     WPM_MAX       = 7'd80;

    // A prosign name holds at most three characters.
    localparam logic [2:0] PROSIGN_NAME_MAX = 3'd3;

    // A symbol has at most nine elements; results per request are capped.
    localparam logic [4:0]  LAST_SLOT  = 5'd17;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_OPEN  = 8'h3C;
    localparam logic [7:0] CHAR_CLOSE = 8'h3E;

    // Span lengths in dot units.
    localparam logic [2:0] UNITS_DOT  = 3'd1;
    localparam logic [2:0] UNITS_DASH = 3'd3;
    localparam logic [2:0] UNITS_WORD = 3'd7;

    typedef enum logic [1:0] {
        PHASE_START   = 2'd0,
        PHASE_TEXT    = 2'd1,
        PHASE_PROSIGN = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        GAP_NONE = 2'd0,
        GAP_CHAR = 2'd1,
        GAP_WORD = 2'd2
    } gap_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_message;
    } in_req_t;

    typedef struct packed {
        logic                 end_of_plan;
        logic                 mark;
        logic [2:0]           span_units;
        logic                 accepted;
        logic [UNITS_W-1:0]   unit_sum;
        logic [DOT_W-1:0]     dot_time_ns;
        logic [TOTAL_W-1:0]   plan_time_ns;
    } out_res_t;

    // A symbol: element count and dash mask, element 0 at the top bit.
    typedef struct packed {
        logic       hit;
        logic [3:0] len;
        logic [8:0] dashes;
    } sym_t;

    function automatic sym_t mk_sym(input logic [3:0] len, input logic [8:0] dashes);
        sym_t s;
        s.hit    = 1'b1;
        s.len    = len;
        s.dashes = dashes;
        return s;
    endfunction

    // Character table of the plain symbols.
    function automatic sym_t sym_lookup(input logic [7:0] c);
        sym_t s;
        s = '0;
        case (c)
            "A": s = mk_sym(4'd2, 9'b010000000);
            "B": s = mk_sym(4'd4, 9'b100000000);
            "C": s = mk_sym(4'd4, 9'b101000000);
            "D": s = mk_sym(4'd3, 9'b100000000);
            "E": s = mk_sym(4'd1, 9'b000000000);
            "F": s = mk_sym(4'd4, 9'b001000000);
            "G": s = mk_sym(4'd3, 9'b110000000);
            "H": s = mk_sym(4'd4, 9'b000000000);
            "I": s = mk_sym(4'd2, 9'b000000000);
            "J": s = mk_sym(4'd4, 9'b011100000);
            "K": s = mk_sym(4'd3, 9'b101000000);
            "L": s = mk_sym(4'd4, 9'b010000000);
            "M": s = mk_sym(4'd2, 9'b110000000);
            "N": s = mk_sym(4'd2, 9'b100000000);
            "O": s = mk_sym(4'd3, 9'b111000000);
            "P": s = mk_sym(4'd4, 9'b011000000);
            "Q": s = mk_sym(4'd4, 9'b110100000);
            "R": s = mk_sym(4'd3, 9'b010000000);
            "S": s = mk_sym(4'd3, 9'b000000000);
            "T": s = mk_sym(4'd1, 9'b100000000);
            "U": s = mk_sym(4'd3, 9'b001000000);
            "V": s = mk_sym(4'd4, 9'b000100000);
            "W": s = mk_sym(4'd3, 9'b011000000);
            "X": s = mk_sym(4'd4, 9'b100100000);
            "Y": s = mk_sym(4'd4, 9'b101100000);
            "Z": s = mk_sym(4'd4, 9'b110000000);
            "0": s = mk_sym(4'd5, 9'b111110000);
            "1": s = mk_sym(4'd5, 9'b011110000);
            "2": s = mk_sym(4'd5, 9'b001110000);
            "3": s = mk_sym(4'd5, 9'b000110000);
            "4": s = mk_sym(4'd5, 9'b000010000);
            "5": s = mk_sym(4'd5, 9'b000000000);
            "6": s = mk_sym(4'd5, 9'b100000000);
            "7": s = mk_sym(4'd5, 9'b110000000);
            "8": s = mk_sym(4'd5, 9'b111000000);
            "9": s = mk_sym(4'd5, 9'b111100000);
            ".": s = mk_sym(4'd6, 9'b010101000);
            ",": s = mk_sym(4'd6, 9'b110011000);
            "?": s = mk_sym(4'd6, 9'b001100000);
            "'": s = mk_sym(4'd6, 9'b011110000);
            "/": s = mk_sym(4'd5, 9'b100100000);
            "!": s = mk_sym(4'd6, 9'b101011000);
            "(": s = mk_sym(4'd5, 9'b101100000);
            ")": s = mk_sym(4'd6, 9'b101101000);
            "&": s = mk_sym(4'd5, 9'b010000000);
            ":": s = mk_sym(4'd6, 9'b111000000);
            ";": s = mk_sym(4'd6, 9'b101010000);
            "=": s = mk_sym(4'd5, 9'b100010000);
            "+": s = mk_sym(4'd5, 9'b010100000);
            "-": s = mk_sym(4'd6, 9'b100001000);
            "\"": s = mk_sym(4'd6, 9'b010010000);
            "$": s = mk_sym(4'd7, 9'b000100100);
            "@": s = mk_sym(4'd6, 9'b011010000);
            default: s = '0;
        endcase
        return s;
    endfunction

    // Prosign table, matched on the packed name and its length.
    function automatic sym_t pro_lookup(input logic [23:0] name, input logic [2:0] len);
        sym_t s;
        s = '0;
        if (len == 3'd2)
        begin
            case (name)
                24'h004152: s = mk_sym(4'd5, 9'b010100000);
                24'h004153: s = mk_sym(4'd5, 9'b010000000);
                24'h00424B: s = mk_sym(4'd7, 9'b100010100);
                24'h004354: s = mk_sym(4'd5, 9'b101010000);
                24'h004B4E: s = mk_sym(4'd5, 9'b101100000);
                24'h00534B: s = mk_sym(4'd6, 9'b000101000);
                default:    s = '0;
            endcase
        end
        else if (len == 3'd3 && name == 24'h534F53)
        begin
            s = mk_sym(4'd9, 9'b000111000);
        end
        return s;
    endfunction

endpackage

### hw/rtl/morse_keying_span_encoder.sv
// ----------------------------------------------------------------------------
// morse_keying_span_encoder: Morse keying span encoder with prosigns
// Turns message characters into mark and space spans and closes each
// message with a summary of its length and timing.
// ----------------------------------------------------------------------------
// Usage
// The input channel (in_valid, in_ready, in_data) takes one character request
// at a time. Each request answers with up to 18 results on the output channel
// (out_valid, out_ready, out_data): the gap before the symbol, then its marks
// and inner spaces, and after the last byte of a message one summary.
// A request is decoded, then sends its spans at one span per cycle while the
// output register is free, then closes; a closing request adds a multiply
// step and the summary.
// A write of cfg_we / cfg_wdata sets the speed and starts the dot divider,
// which holds in_ready low from the write cycle until the division is done.
// A stalled receiver holds the result in the output register; the sequencer
// waits and no result is lost. Reset clears the message and sets 20 words
// per minute, a dot of 60 ms.
// ----------------------------------------------------------------------------
module morse_keying_span_encoder #(
    parameter int unsigned MAX_CHARS = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mkse_pkg::in_req_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mkse_pkg::out_res_t            out_data,
    input  logic                          cfg_we,
    input  logic [mkse_pkg::WPM_W-1:0]    cfg_wdata
);

    localparam int unsigned CW = $clog2(MAX_CHARS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SPAN = 4'b0010,
        S_MUL  = 4'b0100,
        S_SUM  = 4'b1000
    } state_t;

    state_t                                 state_reg, state_next;
    mkse_pkg::phase_t                       phase_reg, phase_next;
    mkse_pkg::gap_t                         gap_reg, gap_next;
    logic [CW-1:0]                          cnt_reg, cnt_next;
    logic [23:0]                            pname_reg, pname_next;
    logic [2:0]                             plen_reg, plen_next;
    logic [mkse_pkg::UNITS_W-1:0]           utot_reg, utot_next;
    logic                                   rej_reg, rej_next;
    logic [mkse_pkg::WPM_W-1:0]             wpm_reg;
    mkse_pkg::gap_t                         sp_gap_reg, sp_gap_next;
    logic [3:0]                             sp_len_reg, sp_len_next;
    logic [3:0]                             sp_idx_reg, sp_idx_next;
    logic [8:0]                             sp_bits_reg, sp_bits_next;
    logic                                   sp_sep_reg, sp_sep_next;
    logic                                   last_reg, last_next;
    logic [4:0]                             sent_reg, sent_next;
    logic [mkse_pkg::TOTAL_W-1:0]           prod_reg, prod_next;
    logic                                   out_valid_reg, out_valid_next;
    mkse_pkg::out_res_t                     out_data_reg, out_data_next;

    logic                                   div_busy;
    logic [mkse_pkg::DOT_W-1:0]             dot_ns;
    logic                                   slot_free;
    logic                                   take;
    mkse_pkg::sym_t                         sym;
    mkse_pkg::sym_t                         pro;
    logic [2:0]                             span_len;
    logic                                   span_key;
    logic [mkse_pkg::UNITS_W:0]             utot_sum;
    logic                                   msg_ok;

    // Dot duration divider, restarted by every speed write.
    mkse_dot_div u_dot_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_we),
        .wpm    (cfg_wdata),
        .busy   (div_busy),
        .dot_ns (dot_ns)
    );

    assign in_ready  = (state_reg == S_IDLE) && !div_busy && !cfg_we;
    assign take      = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign sym       = mkse_pkg::sym_lookup(in_data.character);
    assign pro       = mkse_pkg::pro_lookup(pname_reg, plen_reg);

    // Next span of the current symbol: gap first, then marks and inner spaces.
    always_comb
    begin
        span_key = 1'b0;
        span_len = mkse_pkg::UNITS_DOT;
        if (sp_gap_reg == mkse_pkg::GAP_CHAR)
        begin
            span_len = mkse_pkg::UNITS_DASH;
        end
        else if (sp_gap_reg == mkse_pkg::GAP_WORD)
        begin
            span_len = mkse_pkg::UNITS_WORD;
        end
        else if (!sp_sep_reg)
        begin
            span_key = 1'b1;
            span_len = sp_bits_reg[8] ? mkse_pkg::UNITS_DASH : mkse_pkg::UNITS_DOT;
        end
    end

    assign utot_sum = {1'b0, utot_reg} + (mkse_pkg::UNITS_W + 1)'(span_len);

    // Summary verdict from the message state.
    assign msg_ok = !rej_reg && (phase_reg == mkse_pkg::PHASE_TEXT)
                    && (gap_reg != mkse_pkg::GAP_WORD)
                    && (wpm_reg >= mkse_pkg::WPM_MIN) && (wpm_reg <= mkse_pkg::WPM_MAX);

    // Sequencer: decode a request, send its spans, and close the message after its last request.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        gap_next       = gap_reg;
        cnt_next       = cnt_reg;
        pname_next     = pname_reg;
        plen_next      = plen_reg;
        utot_next      = utot_reg;
        rej_next       = rej_reg;
        sp_gap_next    = sp_gap_reg;
        sp_len_next    = sp_len_reg;
        sp_idx_next    = sp_idx_reg;
        sp_bits_next   = sp_bits_reg;
        sp_sep_next    = sp_sep_reg;
        last_next      = last_reg;
        sent_next      = sent_reg;
        prod_next      = prod_reg;
        out_data_next  = out_data_reg;
        out_valid_next = slot_free ? 1'b0 : out_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next  = S_SPAN;
                    last_next   = in_data.end_of_message;
                    sent_next   = '0;
                    sp_gap_next = mkse_pkg::GAP_NONE;
                    sp_len_next = '0;
                    sp_idx_next = '0;
                    sp_sep_next = 1'b0;
                    if (!rej_reg)
                    begin
                        if (cnt_reg >= CW'(MAX_CHARS))
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CW'(1);
                            if (phase_reg == mkse_pkg::PHASE_PROSIGN)
                            begin
                                if (in_data.character == mkse_pkg::CHAR_CLOSE)
                                begin
                                    pname_next = '0;
                                    plen_next  = '0;
                                    if (!pro.hit)
                                    begin
                                        rej_next = 1'b1;
                                    end
                                    else
                                    begin
                                        sp_gap_next  = gap_reg;
                                        sp_len_next  = pro.len;
                                        sp_bits_next = pro.dashes;
                                        gap_next     = mkse_pkg::GAP_CHAR;
                                        phase_next   = mkse_pkg::PHASE_TEXT;
                                    end
                                end
                                else if (plen_reg >= mkse_pkg::PROSIGN_NAME_MAX)
                                begin
                                    rej_next = 1'b1;
                                end
                                else
                                begin
                                    pname_next = {pname_reg[15:0], in_data.character};
                                    plen_next  = plen_reg + 3'd1;
                                end
                            end
                            else if (in_data.character == mkse_pkg::CHAR_SPACE)
                            begin
                                if (cnt_reg == '0 || gap_reg == mkse_pkg::GAP_WORD)
                                begin
                                    rej_next = 1'b1;
                                end
                                else
                                begin
                                    gap_next = mkse_pkg::GAP_WORD;
                                end
                            end
                            else if (in_data.character == mkse_pkg::CHAR_OPEN)
                            begin
                                sp_gap_next = gap_reg;
                                gap_next    = mkse_pkg::GAP_NONE;
                                phase_next  = mkse_pkg::PHASE_PROSIGN;
                                pname_next  = '0;
                                plen_next   = '0;
                            end
                            else if (!sym.hit)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                sp_gap_next  = gap_reg;
                                sp_len_next  = sym.len;
                                sp_bits_next = sym.dashes;
                                gap_next     = mkse_pkg::GAP_CHAR;
                                phase_next   = mkse_pkg::PHASE_TEXT;
                            end
                        end
                    end
                end
            end

            S_SPAN:
            begin
                if (sp_gap_reg == mkse_pkg::GAP_NONE && sp_idx_reg == sp_len_reg)
                begin
                    state_next = last_reg ? S_MUL : S_IDLE;
                end
                else if (slot_free)
                begin
                    // The last span slot of a closing request goes to the summary.
                    out_valid_next = !(last_reg && sent_reg == mkse_pkg::LAST_SLOT);
                    out_data_next            = '0;
                    out_data_next.mark       = span_key;
                    out_data_next.span_units = span_len;
                    sent_next = sent_reg + 5'd1;
                    utot_next = utot_sum[mkse_pkg::UNITS_W] ? '1
                                : utot_sum[mkse_pkg::UNITS_W-1:0];
                    if (sp_gap_reg != mkse_pkg::GAP_NONE)
                    begin
                        sp_gap_next = mkse_pkg::GAP_NONE;
                    end
                    else if (sp_sep_reg)
                    begin
                        sp_sep_next = 1'b0;
                    end
                    else
                    begin
                        sp_sep_next  = 1'b1;
                        sp_idx_next  = sp_idx_reg + 4'd1;
                        sp_bits_next = {sp_bits_reg[7:0], 1'b0};
                    end
                end
            end

            S_MUL:
            begin
                prod_next  = mkse_pkg::TOTAL_W'(utot_reg) * mkse_pkg::TOTAL_W'(dot_ns);
                state_next = S_SUM;
            end

            S_SUM:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next              = '0;
                    out_data_next.end_of_plan  = 1'b1;
                    out_data_next.accepted     = msg_ok;
                    out_data_next.unit_sum     = utot_reg;
                    out_data_next.dot_time_ns  = dot_ns;
                    out_data_next.plan_time_ns = prod_reg;
                    phase_next = mkse_pkg::PHASE_START;
                    gap_next   = mkse_pkg::GAP_NONE;
                    cnt_next   = '0;
                    pname_next = '0;
                    plen_next  = '0;
                    utot_next  = '0;
                    rej_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and message state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= mkse_pkg::PHASE_START;
            gap_reg       <= mkse_pkg::GAP_NONE;
            cnt_reg       <= '0;
            pname_reg     <= '0;
            plen_reg      <= '0;
            utot_reg      <= '0;
            rej_reg       <= 1'b0;
            wpm_reg       <= mkse_pkg::WPM_RESET;
            sp_gap_reg    <= mkse_pkg::GAP_NONE;
            sp_len_reg    <= '0;
            sp_idx_reg    <= '0;
            sp_sep_reg    <= 1'b0;
            last_reg      <= 1'b0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            gap_reg       <= gap_next;
            cnt_reg       <= cnt_next;
            pname_reg     <= pname_next;
            plen_reg      <= plen_next;
            utot_reg      <= utot_next;
            rej_reg       <= rej_next;
            if (cfg_we)
            begin
                wpm_reg <= cfg_wdata;
            end
            sp_gap_reg    <= sp_gap_next;
            sp_len_reg    <= sp_len_next;
            sp_idx_reg    <= sp_idx_next;
            sp_sep_reg    <= sp_sep_next;
            last_reg      <= last_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sp_bits_reg  <= sp_bits_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks on the sequencer.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE) && !div_busy)
        else $error("request taken while the sequencer is busy");

    a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.end_of_plan |->
            (out_data.span_units == mkse_pkg::UNITS_DOT
             || out_data.span_units == mkse_pkg::UNITS_DASH
             || out_data.span_units == mkse_pkg::UNITS_WORD))
        else $error("span of an illegal length");

    a_sum_product: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_plan |->
            out_data.plan_time_ns == mkse_pkg::TOTAL_W'(out_data.unit_sum)
                * mkse_pkg::TOTAL_W'(out_data.dot_time_ns))
        else $error("summary duration does not match its units");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPAN) |-> (sp_idx_reg <= sp_len_reg))
        else $error("element index ran past the symbol");

endmodule

### hw/rtl/mkse_dot_div.sv
// ----------------------------------------------------------------------------
// mkse_dot_div: dot duration divider
// Works out round(1.2e9 / wpm), wpm clamped to 5..80, with one shared compare-and-subtract step,
// one quotient bit a cycle, after each speed write.
// ----------------------------------------------------------------------------
module mkse_dot_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mkse_pkg::WPM_W-1:0]   wpm,
    output logic                         busy,
    output logic [mkse_pkg::DOT_W-1:0]   dot_ns
);

    localparam int unsigned NW = mkse_pkg::DIV_NUM_W;
    localparam int unsigned WW = mkse_pkg::WPM_W;

    logic                       busy_reg, busy_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic [NW-1:0]              num_reg, num_next;
    logic [WW-1:0]              rem_reg, rem_next;
    logic [WW-1:0]              div_reg, div_next;
    logic [mkse_pkg::DOT_W-1:0] quo_reg, quo_next;
    logic [WW-1:0]              w_clamped;
    logic [WW:0]                trial;
    logic                       q_bit;

    // Speed clamped to the legal range before dividing.
    always_comb
    begin
        if (wpm < mkse_pkg::WPM_MIN)
        begin
            w_clamped = mkse_pkg::WPM_MIN;
        end
        else if (wpm > mkse_pkg::WPM_MAX)
        begin
            w_clamped = mkse_pkg::WPM_MAX;
        end
        else
        begin
            w_clamped = wpm;
        end
    end

    // One restoring division step per cycle.
    assign trial = {rem_reg, num_reg[NW-1]};
    assign q_bit = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(NW - 1);
            num_next  = mkse_pkg::DOT_NUMERATOR + NW'(w_clamped >> 1);
            rem_next  = '0;
            div_next  = w_clamped;
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? WW'(trial - {1'b0, div_reg}) : trial[WW-1:0];
            num_next = {num_reg[NW-2:0], 1'b0};
            quo_next = {quo_reg[mkse_pkg::DOT_W-2:0], q_bit};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            quo_reg  <= mkse_pkg::DOT_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            quo_reg  <= quo_next;
        end
    end

    assign busy   = busy_reg;
    assign dot_ns = quo_reg;

endmodule
